FILE: rtl/core/bchd_pkg.sv
package bchd_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_PRESS_QUALIFY   = 3'd0;
	localparam logic [2:0] CFG_HOLD_THRESHOLD  = 3'd1;
	localparam logic [2:0] CFG_RELEASE_QUALIFY = 3'd2;
	localparam logic [2:0] CFG_MULTICLICK_GAP  = 3'd3;
	localparam logic [2:0] CFG_BUTTON_ID       = 3'd4;
	localparam logic [2:0] CFG_EVENTS_ENABLED  = 3'd5;

	// event codes on the result channel
	localparam logic [2:0] EV_PRESS        = 3'd0;
	localparam logic [2:0] EV_HOLD_START   = 3'd1;
	localparam logic [2:0] EV_HOLD_PROGRESS = 3'd2;
	localparam logic [2:0] EV_HOLD_RELEASE = 3'd3;
	localparam logic [2:0] EV_CLICK        = 3'd4;

	typedef logic [2:0]  cfg_index_t;
	typedef logic [15:0] cfg_data_t;
	typedef logic [15:0] ms16_t;
	typedef logic [31:0] ms32_t;
	typedef logic [7:0]  byte_t;
	typedef logic [2:0]  event_code_t;

endpackage

FILE: rtl/core/bchd_in_if.sv
interface bchd_in_if;
	import bchd_pkg::*;

	logic  valid;
	logic  ready;
	logic  pressed;
	ms32_t now_ms;

	modport source (output valid, output pressed, output now_ms, input ready);
	modport sink (input valid, input pressed, input now_ms, output ready);

endinterface

FILE: rtl/core/bchd_out_if.sv
interface bchd_out_if;
	import bchd_pkg::*;

	logic        valid;
	logic        ready;
	event_code_t event_code;
	byte_t       click_count;
	ms32_t       hold_ms;
	byte_t       source_id;

	modport source (output valid, output event_code, output click_count, output hold_ms,
		output source_id, input ready);
	modport sink (input valid, input event_code, input click_count, input hold_ms,
		input source_id, output ready);

endinterface

FILE: rtl/core/button_click_hold_detector_unit.sv
// Button click / hold detector.
// in_ch carries one poll of the button per beat: pressed level and the
// free-running millisecond time now_ms. out_ch carries at most one event per
// poll: event_code, click_count, hold_ms and source_id (the button id).
// The cfg port (cfg_we, cfg_index, cfg_data) writes the timing registers,
// the button id and the event enable; write only while the block is idle.
// Path: a poll is taken into the input register, is evaluated there against
// the state, and its event is written to the result register that drives
// out_ch when the poll advances (not while out_ch holds an untaken event).
// Throughput: one poll per cycle while out_ch is not stalled; the state
// machine step is combinational, so a poll can follow on every clock.
// Stall: while out_ch holds an event that is not taken, the input register
// keeps its poll and in_ch accepts no more than that one extra beat.
// Reset (arst_n low): state machine to idle, timers and click count cleared,
// registers back to 50/1000/50/300 ms, id 0, events enabled.
module button_click_hold_detector_unit #(
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  bchd_pkg::cfg_index_t  cfg_index,
	input  bchd_pkg::cfg_data_t   cfg_data,
	bchd_in_if.sink               in_ch,
	bchd_out_if.source            out_ch
);
	import bchd_pkg::*;

	// time differences are reduced modulo 2^TIME_BITS, then kept to 32 bits
	localparam logic [31:0] DiffMask = (TIME_BITS >= 32) ? 32'hFFFF_FFFF
		: 32'((64'd1 << TIME_BITS) - 64'd1);

	// state codes
	localparam logic [3:0] ST_IDLE        = 4'd0;
	localparam logic [3:0] ST_QUALIFY     = 4'd1;
	localparam logic [3:0] ST_PRESSED     = 4'd2;
	localparam logic [3:0] ST_WAIT_HOLD   = 4'd3;
	localparam logic [3:0] ST_RELEASE     = 4'd4;
	localparam logic [3:0] ST_CLICK       = 4'd5;
	localparam logic [3:0] ST_WAIT_MULTI  = 4'd6;
	localparam logic [3:0] ST_HOLD        = 4'd7;
	localparam logic [3:0] ST_HOLD_PASSED = 4'd8;

	// configuration registers
	ms16_t press_qual_q, hold_thr_q, release_qual_q, multi_gap_q;
	byte_t button_id_q;
	logic  events_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_qual_q   <= 16'd50;
			hold_thr_q     <= 16'd1000;
			release_qual_q <= 16'd50;
			multi_gap_q    <= 16'd300;
			button_id_q    <= 8'd0;
			events_en_q    <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRESS_QUALIFY:   press_qual_q   <= cfg_data;
				CFG_HOLD_THRESHOLD:  hold_thr_q     <= cfg_data;
				CFG_RELEASE_QUALIFY: release_qual_q <= cfg_data;
				CFG_MULTICLICK_GAP:  multi_gap_q    <= cfg_data;
				CFG_BUTTON_ID:       button_id_q    <= cfg_data[7:0];
				CFG_EVENTS_ENABLED:  events_en_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	logic  valid_s1;
	logic  pressed_s1;
	ms32_t now_s1;
	logic  out_valid_q;
	logic  advance;

	assign advance     = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			pressed_s1 <= in_ch.pressed;
			now_s1     <= in_ch.now_ms;
		end
	end

	// machine state
	logic [3:0] state_q;
	ms32_t      tstart_q, hbegin_q, helap_q;
	ms16_t      tlen_q;
	byte_t      clicks_q;

	// timer and hold time differences
	ms32_t timer_diff, hold_diff;
	logic  timer_done;

	assign timer_diff = (now_s1 - tstart_q) & DiffMask;
	assign hold_diff  = (now_s1 - hbegin_q) & DiffMask;
	assign timer_done = timer_diff >= {16'd0, tlen_q};

	// next state and event for the registered poll
	logic [3:0]  state_d;
	ms32_t       tstart_d, hbegin_d, helap_d;
	ms16_t       tlen_d;
	byte_t       clicks_d;
	logic        emit;
	event_code_t code_d;
	byte_t       cnt_d;
	ms32_t       hms_d;

	always_comb begin
		state_d  = state_q;
		tstart_d = tstart_q;
		tlen_d   = tlen_q;
		hbegin_d = hbegin_q;
		helap_d  = helap_q;
		clicks_d = clicks_q;
		emit     = 1'b0;
		code_d   = EV_PRESS;
		cnt_d    = 8'd0;
		hms_d    = 32'd0;
		if (pressed_s1) begin
			case (state_q)
				ST_IDLE: begin
					state_d  = ST_QUALIFY;
					tstart_d = now_s1;
					tlen_d   = press_qual_q;
					hbegin_d = now_s1;
				end
				ST_QUALIFY: begin
					if (timer_done) state_d = ST_PRESSED;
				end
				ST_PRESSED: begin
					state_d  = ST_WAIT_HOLD;
					tstart_d = now_s1;
					tlen_d   = hold_thr_q;
					emit     = 1'b1;
					code_d   = EV_PRESS;
				end
				ST_WAIT_HOLD: begin
					if (timer_done) begin
						state_d = ST_HOLD;
						emit    = 1'b1;
						code_d  = EV_HOLD_START;
					end
				end
				ST_WAIT_MULTI: begin
					if (!timer_done) begin
						state_d  = ST_QUALIFY;
						tstart_d = now_s1;
						tlen_d   = press_qual_q;
						hbegin_d = now_s1;
					end
				end
				ST_HOLD: begin
					helap_d = hold_diff;
					emit    = 1'b1;
					code_d  = EV_HOLD_PROGRESS;
					hms_d   = hold_diff + {16'd0, hold_thr_q};
				end
				default: ;
			endcase
		end else begin
			case (state_q)
				ST_WAIT_HOLD: begin
					state_d  = ST_RELEASE;
					tstart_d = now_s1;
					tlen_d   = release_qual_q;
				end
				ST_RELEASE: begin
					if (timer_done) begin
						state_d = ST_CLICK;
						// count saturates at its top value
						if (clicks_q != 8'hFF) clicks_d = clicks_q + 8'd1;
						emit   = 1'b1;
						code_d = EV_CLICK;
						cnt_d  = clicks_d;
					end
				end
				ST_HOLD: begin
					state_d  = ST_HOLD_PASSED;
					tlen_d   = 16'd0;
					clicks_d = 8'd0;
					emit     = 1'b1;
					code_d   = EV_HOLD_RELEASE;
					hms_d    = helap_q + {16'd0, hold_thr_q};
				end
				ST_CLICK: begin
					state_d  = ST_WAIT_MULTI;
					tstart_d = now_s1;
					tlen_d   = multi_gap_q;
				end
				ST_WAIT_MULTI: begin
					if (timer_done) begin
						state_d  = ST_IDLE;
						tlen_d   = 16'd0;
						clicks_d = 8'd0;
					end
				end
				default: state_d = ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tstart_q <= 32'd0;
			tlen_q   <= 16'd0;
			hbegin_q <= 32'd0;
			helap_q  <= 32'd0;
			clicks_q <= 8'd0;
		end else if (advance) begin
			state_q  <= state_d;
			tstart_q <= tstart_d;
			tlen_q   <= tlen_d;
			hbegin_q <= hbegin_d;
			helap_q  <= helap_d;
			clicks_q <= clicks_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit && events_en_q;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit && events_en_q) begin
			out_ch.event_code  <= code_d;
			out_ch.click_count <= cnt_d;
			out_ch.hold_ms     <= hms_d;
			out_ch.source_id   <= button_id_q;
		end
	end

	assign out_ch.valid = out_valid_q;

`ifndef SYNTHESIS
	// machine state only moves when a poll is evaluated
	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q) && $stable(clicks_q))
		else $error("state changed without a poll");

	// a new event beat comes only from an evaluated poll with events on
	a_event_source: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !(emit && events_en_q) |=> !out_ch.valid)
		else $error("event beat without an emitting poll");

	// input only backs up when both the input and result registers are full
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> valid_s1 && out_valid_q && !out_ch.ready)
		else $error("input stalled with room to spare");
`endif

endmodule
